// ===== design/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest-remaining-time scheduler package
// Command codes, field widths and the layout of one process-table row.
// ----------------------------------------------------------------------------
package srtf_pkg;

	// Field widths.
	localparam int unsigned ID_W   = 16;
	localparam int unsigned TIME_W = 24;
	localparam int unsigned CNT_CFG_W = 5;

	// Saturation point of the scheduler clock.
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Command codes carried on the cmd port.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// One row of the process table.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [15:0]       arrival;
		logic [15:0]       remaining;
		logic [TIME_W-1:0] first_start;
	} row_t;

endpackage

// ===== design/shortest_remaining_time_scheduler.sv =====
// ----------------------------------------------------------------------------
// Shortest-remaining-time scheduler
// Preemptive scheduler over a table of process slots held in a small memory.
// A tick scans the slots in use one per cycle through a shared compare unit,
// then runs the winner, if any, for one time unit and reports its completion times when it finishes.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transaction when
//  -------   ---------------------------------------   ---------------------------
//  command   start, busy, cmd, slot, proc_id,          start high, busy low
//            arrival, burst
//  config    cfg_valid, cfg_ready, cfg_data            cfg_valid and cfg_ready high
//  result    result_valid, status, ran, run_id,        result_valid high (one cycle)
//            finished, turnaround, response,
//            all_finished, time_now
//
// A load or an unknown command goes from ST_IDLE to ST_REPORT, which registers
// the result. A tick runs ST_SCAN, then ST_PICK_RD and ST_PICK_UPD when a slot
// runs, then ST_REPORT; the slot scan reads one table row per cycle from the
// single read port. A clear sweeps zeros through all MAX_SLOTS rows and then
// reports. No clearing pass runs after reset.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
	parameter int unsigned MAX_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [3:0]                    slot,
	input  logic [srtf_pkg::ID_W-1:0]     proc_id,
	input  logic [15:0]                   arrival,
	input  logic [15:0]                   burst,
	// Configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srtf_pkg::CNT_CFG_W-1:0] cfg_data,
	// Result channel
	output logic                          result_valid,
	output logic                          status,
	output logic                          ran,
	output logic [srtf_pkg::ID_W-1:0]     run_id,
	output logic                          finished,
	output logic [srtf_pkg::TIME_W-1:0]   turnaround,
	output logic [srtf_pkg::TIME_W-1:0]   response,
	output logic                          all_finished,
	output logic [srtf_pkg::TIME_W-1:0]   time_now
);

	import srtf_pkg::*;

	localparam int unsigned IW    = $clog2(MAX_SLOTS);
	localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CW    = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
	localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK_RD,
		ST_PICK_UPD,
		ST_CLEAR,
		ST_REPORT
	} state_t;

	state_t                state_q;
	logic [CNT_CFG_W-1:0]  pc_q;
	logic [TIME_W-1:0]     time_q;
	logic [MAX_SLOTS-1:0]  started_q;
	logic [MAX_SLOTS-1:0]  done_vec_q;

	// Scan and pick bookkeeping.
	logic [CNT_W-1:0]      scan_idx_q;
	logic                  cmp_valid_s1;
	logic [IW-1:0]         cmp_idx_s1;
	logic                  found_q;
	logic [IW-1:0]         pick_q;
	logic [15:0]           best_q;

	// Per-transaction report fields.
	logic                  it_status_q;
	logic                  it_ran_q;
	logic                  it_fin_q;
	logic [ID_W-1:0]       it_id_q;
	logic [15:0]           it_arr_q;
	logic [TIME_W-1:0]     it_start_q;

	// Result registers.
	logic                  res_valid_q;
	logic                  res_status_q;
	logic                  res_ran_q;
	logic [ID_W-1:0]       res_id_q;
	logic                  res_fin_q;
	logic [TIME_W-1:0]     res_tat_q;
	logic [TIME_W-1:0]     res_resp_q;
	logic                  res_all_q;
	logic [TIME_W-1:0]     res_time_q;

	// Process table memory.
	row_t                  mem [MAX_SLOTS];
	row_t                  rd_row_q;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	row_t                  mem_wdata;
	logic [IW-1:0]         mem_raddr;

	// Derived combinational values.
	logic [CNT_W-1:0]      n_use;
	logic [MAX_SLOTS-1:0]  in_use_mask;
	logic                  accept;
	logic                  load_reject;
	logic [IW-1:0]         load_addr;
	logic                  issue_en;
	logic                  eligible;
	logic [15:0]           new_rem;
	logic [TIME_W-1:0]     start_val;
	logic [TIME_W-1:0]     time_inc;

	// Slots in use, capped at the table depth.
	always_comb begin
		if (CW'(pc_q) > CW'(MAX_SLOTS)) begin
			n_use = CNT_W'(MAX_SLOTS);
		end else begin
			n_use = CNT_W'(pc_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			in_use_mask[i] = (CNT_W'(i) < n_use);
		end
	end

	assign accept      = start && (state_q == ST_IDLE);
	assign load_reject = (burst == 16'd0) || (CW'(slot) >= CW'(n_use));
	assign load_addr   = IW'(slot);
	assign issue_en    = (scan_idx_q < n_use);

	// Shared compare unit: is the row just read a better candidate.
	assign eligible = cmp_valid_s1 && !done_vec_q[cmp_idx_s1] &&
		({{(TIME_W-16){1'b0}}, rd_row_q.arrival} <= time_q) &&
		(!found_q || (rd_row_q.remaining < best_q));

	// Update values for the slot that runs.
	assign new_rem   = (rd_row_q.remaining == 16'd0) ? 16'd0 : rd_row_q.remaining - 16'd1;
	assign start_val = started_q[pick_q] ? rd_row_q.first_start : time_q;
	assign time_inc  = (time_q == TIME_MAX) ? TIME_MAX : time_q + 1'b1;

	// Memory port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = load_addr;
		mem_wdata = '0;
		mem_raddr = scan_idx_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_LOAD) && !load_reject) begin
					mem_we              = 1'b1;
					mem_wdata.id        = proc_id;
					mem_wdata.arrival   = arrival;
					mem_wdata.remaining = burst;
				end
			end
			ST_PICK_RD: begin
				mem_raddr = pick_q;
			end
			ST_PICK_UPD: begin
				mem_we                = 1'b1;
				mem_waddr             = pick_q;
				mem_wdata.id          = rd_row_q.id;
				mem_wdata.arrival     = rd_row_q.arrival;
				mem_wdata.remaining   = new_rem;
				mem_wdata.first_start = start_val;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = scan_idx_q[IW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Process table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_row_q <= mem[mem_raddr];
	end

	// Sequencer, scheduler state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= CNT_CFG_W'(1);
			time_q       <= '0;
			started_q    <= '0;
			done_vec_q   <= '0;
			scan_idx_q   <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_idx_s1   <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			best_q       <= '0;
			it_status_q  <= 1'b0;
			it_ran_q     <= 1'b0;
			it_fin_q     <= 1'b0;
			it_id_q      <= '0;
			it_arr_q     <= '0;
			it_start_q   <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= 1'b0;
			res_ran_q    <= 1'b0;
			res_id_q     <= '0;
			res_fin_q    <= 1'b0;
			res_tat_q    <= '0;
			res_resp_q   <= '0;
			res_all_q    <= 1'b0;
			res_time_q   <= '0;
		end else begin
			res_valid_q <= 1'b0;

			// Configuration write.
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						it_status_q  <= 1'b0;
						it_ran_q     <= 1'b0;
						it_fin_q     <= 1'b0;
						scan_idx_q   <= '0;
						cmp_valid_s1 <= 1'b0;
						found_q      <= 1'b0;
						case (cmd)
							CMD_LOAD: begin
								if (load_reject) begin
									it_status_q <= 1'b1;
								end else begin
									started_q[load_addr]  <= 1'b0;
									done_vec_q[load_addr] <= 1'b0;
								end
								state_q <= ST_REPORT;
							end
							CMD_TICK: begin
								state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								started_q  <= '0;
								done_vec_q <= '0;
								time_q     <= '0;
								state_q    <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_REPORT;
							end
						endcase
					end
				end

				// One row issued and one row compared per cycle.
				ST_SCAN: begin
					cmp_valid_s1 <= issue_en;
					cmp_idx_s1   <= scan_idx_q[IW-1:0];
					if (issue_en) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (eligible) begin
						found_q <= 1'b1;
						best_q  <= rd_row_q.remaining;
						pick_q  <= cmp_idx_s1;
					end
					if (!issue_en && !cmp_valid_s1) begin
						if (found_q) begin
							state_q <= ST_PICK_RD;
						end else begin
							time_q  <= time_inc;
							state_q <= ST_REPORT;
						end
					end
				end

				ST_PICK_RD: begin
					state_q <= ST_PICK_UPD;
				end

				// Run the picked slot for one unit.
				ST_PICK_UPD: begin
					started_q[pick_q] <= 1'b1;
					if (new_rem == 16'd0) begin
						done_vec_q[pick_q] <= 1'b1;
						it_fin_q           <= 1'b1;
					end
					time_q     <= time_inc;
					it_ran_q   <= 1'b1;
					it_id_q    <= rd_row_q.id;
					it_arr_q   <= rd_row_q.arrival;
					it_start_q <= start_val;
					state_q    <= ST_REPORT;
				end

				// Zero every table row, one per cycle.
				ST_CLEAR: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q[IW-1:0] == LAST_SLOT) begin
						state_q <= ST_REPORT;
					end
				end

				// Form the result and show it for one cycle.
				ST_REPORT: begin
					res_valid_q  <= 1'b1;
					res_status_q <= it_status_q;
					res_ran_q    <= it_ran_q;
					res_id_q     <= it_ran_q ? it_id_q : '0;
					res_fin_q    <= it_fin_q;
					res_tat_q    <= it_fin_q ?
						time_q - {{(TIME_W-16){1'b0}}, it_arr_q} : '0;
					res_resp_q   <= it_fin_q ?
						it_start_q - {{(TIME_W-16){1'b0}}, it_arr_q} : '0;
					res_all_q    <= &(done_vec_q | ~in_use_mask);
					res_time_q   <= time_q;
					state_q      <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign ran          = res_ran_q;
	assign run_id       = res_id_q;
	assign finished     = res_fin_q;
	assign turnaround   = res_tat_q;
	assign response     = res_resp_q;
	assign all_finished = res_all_q;
	assign time_now     = res_time_q;

endmodule
